### rtl/ibcc_pkg.sv
`timescale 1ns / 1ps

package ibcc_pkg;

	// Frame layout: accel x, y, z, then gyro x, y, z.
	localparam int unsigned AXES       = 6;
	localparam int unsigned AXIS_W     = $clog2(AXES);
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned TIME_W     = 32;

	// The z-accelerometer lane carries gravity in its bias.
	localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = AXIS_W'(2);
	localparam logic [AXIS_W-1:0] AXIS_LAST    = AXIS_W'(AXES - 1);

	// Configuration registers.
	localparam int unsigned CALIB_W     = 10;
	localparam int unsigned GRAVITY_W   = 15;
	localparam int unsigned CFG_DATA_W  = 15;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_COUNT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY     = 1'b1;

	localparam logic [CALIB_W-1:0]   CALIB_RESET   = 10'd500;
	localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 15'd4096;

	// Default width of the calibration frame counter.
	localparam int unsigned COUNT_BITS_DEF = 10;

	// Saturation limits of the corrected samples.
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef sample_t                    axes_t [AXES];

	typedef enum logic [1:0] {
		ST_CAL,
		ST_DIV_ISSUE,
		ST_DIV_WAIT,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              acc;
		logic              div_start;
		logic              off_wr;
		logic [AXIS_W-1:0] axis;
		logic              load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cal_last;
		logic div_done;
		logic out_full;
	} stat_t;

endpackage

### rtl/ibcc_in_if.sv
`timescale 1ns / 1ps

interface ibcc_in_if import ibcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic signed [15:0]  accel_x;
	logic signed [15:0]  accel_y;
	logic signed [15:0]  accel_z;
	logic signed [15:0]  gyro_x;
	logic signed [15:0]  gyro_y;
	logic signed [15:0]  gyro_z;
	logic [TIME_W-1:0]   time_ms;

	modport source (
		output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
		input  ready
	);
	modport sink (
		input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
		output ready
	);
endinterface

### rtl/ibcc_out_if.sv
`timescale 1ns / 1ps

interface ibcc_out_if import ibcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   time_ms_out;
	logic signed [15:0]  corr_accel_x;
	logic signed [15:0]  corr_accel_y;
	logic signed [15:0]  corr_accel_z;
	logic signed [15:0]  corr_gyro_x;
	logic signed [15:0]  corr_gyro_y;
	logic signed [15:0]  corr_gyro_z;

	modport source (
		output valid, time_ms_out, corr_accel_x, corr_accel_y, corr_accel_z,
		       corr_gyro_x, corr_gyro_y, corr_gyro_z,
		input  ready
	);
	modport sink (
		input  valid, time_ms_out, corr_accel_x, corr_accel_y, corr_accel_z,
		       corr_gyro_x, corr_gyro_y, corr_gyro_z,
		output ready
	);
endinterface

### rtl/imu_bias_calibrate_correct_unit.sv
`timescale 1ns / 1ps

// IMU bias calibration and correction.
// Requests on in_ch carry one six-axis frame (accel x, y, z, gyro x, y, z)
// and a millisecond timestamp; corrected frames leave on out_ch. Both use a
// valid/ready handshake. cfg_wen/cfg_index/cfg_data write calib_count
// (index 0) and gravity_counts (index 1); the user must write them only
// while the block is idle, as the block does not enforce it. After reset
// the block calibrates: it takes one request per cycle, sums the first
// calib_count frames and returns nothing for them. The last of them starts
// six signed divisions on one shared bit-serial divider, during which
// in_ch.ready is low. The z-accelerometer offset also loses one g. From
// then on every request returns one result, raw minus offset saturated to
// 16 bits, in the cycle after acceptance, at one frame per cycle; the output
// register lets a new request in while the previous result is taken, but
// while the receiver stalls with a result held, in_ch.ready is low. Reset
// clears the sums and counter and restores the register defaults.
module imu_bias_calibrate_correct_unit import ibcc_pkg::*; #(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	ibcc_in_if.sink                in_ch,
	ibcc_out_if.source             out_ch
);

	cmd_t  cmd;
	stat_t stat;
	axes_t raw;
	axes_t corr;

	// Frame fields in lane order.
	assign raw[0] = in_ch.accel_x;
	assign raw[1] = in_ch.accel_y;
	assign raw[2] = in_ch.accel_z;
	assign raw[3] = in_ch.gyro_x;
	assign raw[4] = in_ch.gyro_y;
	assign raw[5] = in_ch.gyro_z;

	ibcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.in_ready  (in_ch.ready),
		.cmd       (cmd)
	);

	ibcc_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.raw       (raw),
		.time_in   (in_ch.time_ms),
		.cmd       (cmd),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.out_valid (out_ch.valid),
		.corr      (corr),
		.time_out  (out_ch.time_ms_out)
	);

	assign out_ch.corr_accel_x = corr[0];
	assign out_ch.corr_accel_y = corr[1];
	assign out_ch.corr_accel_z = corr[2];
	assign out_ch.corr_gyro_x  = corr[3];
	assign out_ch.corr_gyro_y  = corr[4];
	assign out_ch.corr_gyro_z  = corr[5];

endmodule

### rtl/ibcc_div.sv
`timescale 1ns / 1ps

module ibcc_div import ibcc_pkg::*; #(
	parameter int unsigned NUM_W = 26,
	parameter int unsigned DEN_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NUM_W-1:0] num_abs;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             fits;

	// Restoring division on magnitudes, one quotient bit per cycle.
	always_comb begin
		num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num_abs;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	// Truncation toward zero: negate the magnitude quotient for a negative sum.
	assign quot = neg_q ? $signed(~num_q + 1'b1) : $signed(num_q);
	assign done = done_q;

endmodule

### rtl/ibcc_dp.sv
`timescale 1ns / 1ps

module ibcc_dp import ibcc_pkg::*; #(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  axes_t                  raw,
	input  logic [TIME_W-1:0]      time_in,
	input  cmd_t                   cmd,
	input  logic                   out_ready,
	output stat_t                  stat,
	output logic                   out_valid,
	output axes_t                  corr,
	output logic [TIME_W-1:0]      time_out
);

	localparam int unsigned SUM_W = SAMPLE_W + COUNT_BITS;
	localparam int unsigned N_W   = COUNT_BITS + 1;
	localparam int unsigned CMP_W = (N_W > CALIB_W) ? N_W : CALIB_W;

	logic [CALIB_W-1:0]   calib_count_q;
	logic [GRAVITY_W-1:0] gravity_q;
	logic [N_W-1:0]       frame_count_q;
	logic signed [SUM_W-1:0] sums_q [AXES];
	axes_t                offs_q;
	axes_t                corr_q;
	logic [TIME_W-1:0]    time_q;
	logic                 out_valid_q;

	logic [N_W-1:0]          n_next;
	logic [CALIB_W-1:0]      target;
	logic                    cal_last;
	logic signed [SUM_W-1:0] quot;
	logic                    div_done;
	sample_t                 quot16;
	axes_t                   corr_d;

	// Configuration registers; an index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_count_q <= CALIB_RESET;
			gravity_q     <= GRAVITY_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_CALIB_COUNT: calib_count_q <= cfg_data[CALIB_W-1:0];
				CFG_GRAVITY:     gravity_q     <= cfg_data[GRAVITY_W-1:0];
				default: ;
			endcase
		end
	end

	// End of calibration: enough frames seen, or the counter is full.
	always_comb begin
		n_next   = frame_count_q + 1'b1;
		target   = (calib_count_q == '0) ? CALIB_W'(1) : calib_count_q;
		cal_last = (CMP_W'(n_next) >= CMP_W'(target)) || n_next[COUNT_BITS];
	end

	// Frame counter and per-axis sums; after the last frame the counter holds
	// the number of frames summed, which is the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			for (int i = 0; i < AXES; i++) begin
				sums_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			frame_count_q <= n_next;
			for (int i = 0; i < AXES; i++) begin
				sums_q[i] <= sums_q[i] + SUM_W'(raw[i]);
			end
		end
	end

	// Shared divider, one axis at a time.
	ibcc_div #(
		.NUM_W (SUM_W),
		.DEN_W (N_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (sums_q[cmd.axis]),
		.den    (frame_count_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign quot16 = quot[SAMPLE_W-1:0];

	// Offsets; the z-accelerometer one has gravity removed, wrapping to 16 bits.
	always_ff @(posedge clk) begin
		if (cmd.off_wr) begin
			if (cmd.axis == AXIS_ACCEL_Z) begin
				offs_q[cmd.axis] <= quot16 - $signed({1'b0, gravity_q});
			end else begin
				offs_q[cmd.axis] <= quot16;
			end
		end
	end

	// Correction lanes: raw minus offset, saturated.
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			logic signed [SAMPLE_W:0] diff;
			diff = {raw[i][SAMPLE_W-1], raw[i]} - {offs_q[i][SAMPLE_W-1], offs_q[i]};
			if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
				corr_d[i] = diff[SAMPLE_W] ? SAT_MIN : SAT_MAX;
			end else begin
				corr_d[i] = diff[SAMPLE_W-1:0];
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			corr_q <= corr_d;
			time_q <= time_in;
		end
	end

	assign stat      = '{cal_last: cal_last, div_done: div_done, out_full: out_valid_q};
	assign out_valid = out_valid_q;
	assign corr      = corr_q;
	assign time_out  = time_q;

endmodule

### rtl/ibcc_ctrl.sv
`timescale 1ns / 1ps

module ibcc_ctrl import ibcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output logic  in_ready,
	output cmd_t  cmd
);

	state_t            state_q, state_d;
	logic [AXIS_W-1:0] axis_q, axis_d;

	// State and axis registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CAL;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.axis = axis_q;
		case (state_q)
			ST_CAL: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (stat.cal_last) begin
						axis_d  = '0;
						state_d = ST_DIV_ISSUE;
					end
				end
			end
			ST_DIV_ISSUE: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.off_wr = 1'b1;
					if (axis_q == AXIS_LAST) begin
						state_d = ST_RUN;
					end else begin
						axis_d  = axis_q + 1'b1;
						state_d = ST_DIV_ISSUE;
					end
				end
			end
			ST_RUN: begin
				in_ready = !stat.out_full || out_ready;
				cmd.load = in_valid && in_ready;
			end
			default: begin
				state_d = ST_CAL;
			end
		endcase
	end

endmodule

### rtl/ibcc_checker.sv
`timescale 1ns / 1ps

module ibcc_checker import ibcc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [TIME_W-1:0]   time_ms_out,
	input sample_t             corr_accel_x,
	input sample_t             corr_accel_z,
	input sample_t             corr_gyro_z
);

	// A held result stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its timestamp and its accel x, accel z and gyro z lanes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(time_ms_out) && $stable(corr_accel_x)
			&& $stable(corr_accel_z) && $stable(corr_gyro_z))
		else $error("stalled result changed");

	// A rising out_valid only follows an accepted request in the cycle before.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without a request");

	// With a result stalled, no request is taken that would overwrite it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted over a stalled result");

endmodule

bind imu_bias_calibrate_correct_unit ibcc_checker u_ibcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.time_ms_out  (out_ch.time_ms_out),
	.corr_accel_x (out_ch.corr_accel_x),
	.corr_accel_z (out_ch.corr_accel_z),
	.corr_gyro_z  (out_ch.corr_gyro_z)
);
